### sv/gcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_pkg: shared types for the graph coloring counter
// Payload structs, configuration register codes and the command and status
// bundles between the search controller and the datapath.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int ROW_W         = 32;
  localparam int ROW_IDX_W     = 5;
  localparam int COUNT_W       = 64;
  localparam int NODE_COUNT_W  = 6;
  localparam int COLOR_COUNT_W = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 8;

  localparam logic [NODE_COUNT_W-1:0]  NODE_COUNT_RST  = 6'd20;
  localparam logic [COLOR_COUNT_W-1:0] COLOR_COUNT_RST = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT  = 4'd0,
    CFG_COLOR_COUNT = 4'd1
  } gcc_cfg_idx_e;

  // one adjacency row request
  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_bits;
    logic                 last_row;
  } gcc_row_t;

  // one result
  typedef struct packed {
    logic [COUNT_W-1:0] coloring_count;
    logic               count_saturated;
  } gcc_result_t;

  // configuration write
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } gcc_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic write_row;  // store the accepted row
    logic start;      // clear depth and candidate; count 1 if no nodes, else 0
    logic fetch;      // read the row of the current node
    logic descend;    // take the chosen color, go one node deeper
    logic leaf_add;   // add all colors left at the last node
    logic backtrack;  // go one node up, resume past its color
    logic load_out;   // copy the count to the result register
  } gcc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty_graph;  // no nodes in use
    logic found;        // a usable color remains at this node
    logic leaf;         // current node is the last one
    logic root;         // current node is node 0
  } gcc_stat_t;

endpackage

### sv/gcc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_stream_if: valid/ready channel
// Carries one payload per request; source drives valid and payload, sink
// drives ready.
// ----------------------------------------------------------------------------
interface gcc_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### sv/gcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_ctrl: search sequencer
// Loads rows, walks the backtracking search node by node and hands the
// final count to the result register.
// ----------------------------------------------------------------------------
module gcc_ctrl import gcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_last_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  gcc_stat_t stat_i,
  output gcc_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_TRY   = 4'b0100,
    ST_DONE  = 4'b1000
  } gcc_state_e;

  gcc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~rsp_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.write_row = 1'b1;
          if (req_last_i) begin
            cmd_o.start = 1'b1;
            state_d     = stat_i.empty_graph ? ST_DONE : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_TRY;
      end
      ST_TRY: begin
        if (stat_i.leaf) begin
          cmd_o.leaf_add = 1'b1;
          if (stat_i.root) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.backtrack = 1'b1;
            state_d         = ST_FETCH;
          end
        end else if (stat_i.found) begin
          cmd_o.descend = 1'b1;
          state_d       = ST_FETCH;
        end else if (stat_i.root) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.backtrack = 1'b1;
          state_d         = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

### sv/gcc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_dp: search datapath
// Row memory, per-node color cells, conflict check, candidate pick and the
// saturating coloring counter.
// ----------------------------------------------------------------------------
module gcc_dp import gcc_pkg::*; #(
  parameter int MAX_NODES  = 32,
  parameter int MAX_COLORS = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gcc_row_t                 row_i,
  input  logic [NODE_COUNT_W-1:0]  node_count_i,
  input  logic [COLOR_COUNT_W-1:0] color_count_i,
  input  gcc_cmd_t                 cmd_i,
  output gcc_stat_t                stat_o,
  output logic [COUNT_W-1:0]       count_o
);

  localparam int NIW   = $clog2(MAX_NODES);
  localparam int DW    = $clog2(MAX_NODES + 1);
  localparam int CW    = $clog2(MAX_COLORS);
  localparam int AW    = $clog2(MAX_COLORS + 1);
  localparam int SCANN = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

  logic [ROW_W-1:0]   adj_mem [MAX_NODES];
  logic [ROW_W-1:0]   row_q;
  logic [CW-1:0]      colors_q [MAX_NODES];
  logic [DW-1:0]      depth_q, depth_d, depth_m1;
  logic [AW-1:0]      cand_q, cand_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] res_q;

  logic [DW-1:0]         active_nodes;
  logic [AW-1:0]         active_colors;
  logic [MAX_COLORS-1:0] forbidden, allowed;
  logic [CW-1:0]         pick;
  logic [AW-1:0]         leaf_pc;
  logic [COUNT_W:0]      sum;

  // clamp the configured sizes
  always_comb begin
    if (int'(node_count_i) > MAX_NODES) begin
      active_nodes = DW'(MAX_NODES);
    end else begin
      active_nodes = DW'(node_count_i);
    end
    if (int'(color_count_i) > MAX_COLORS) begin
      active_colors = AW'(MAX_COLORS);
    end else begin
      active_colors = AW'(color_count_i);
    end
  end

  // colors taken by earlier neighbors
  always_comb begin
    forbidden = '0;
    for (int j = 0; j < SCANN; j++) begin
      for (int c = 0; c < MAX_COLORS; c++) begin
        if (row_q[j] && (DW'(j) < depth_q) && (colors_q[j] == CW'(c))) begin
          forbidden[c] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    pick    = '0;
    leaf_pc = '0;
    for (int c = 0; c < MAX_COLORS; c++) begin
      allowed[c] = (AW'(c) < active_colors) && (AW'(c) >= cand_q) && !forbidden[c];
    end
    for (int c = MAX_COLORS - 1; c >= 0; c--) begin
      if (allowed[c]) begin
        pick = CW'(c);
      end
    end
    for (int c = 0; c < MAX_COLORS; c++) begin
      leaf_pc = leaf_pc + AW'(allowed[c]);
    end
  end

  assign depth_m1 = depth_q - DW'(1);
  assign sum      = {1'b0, count_q} + (COUNT_W + 1)'(leaf_pc);

  always_comb begin
    depth_d = depth_q;
    cand_d  = cand_q;
    count_d = count_q;
    if (cmd_i.start) begin
      depth_d = '0;
      cand_d  = '0;
      count_d = (active_nodes == '0) ? COUNT_W'(1) : '0;
    end
    if (cmd_i.descend) begin
      depth_d = depth_q + DW'(1);
      cand_d  = '0;
    end
    if (cmd_i.backtrack) begin
      depth_d = depth_m1;
      cand_d  = AW'(colors_q[depth_m1[NIW-1:0]]) + AW'(1);
    end
    if (cmd_i.leaf_add) begin
      count_d = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      cand_q  <= '0;
      count_q <= '0;
    end else begin
      depth_q <= depth_d;
      cand_q  <= cand_d;
      count_q <= count_d;
    end
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_row && (int'(row_i.row_index) < MAX_NODES)) begin
      adj_mem[NIW'(row_i.row_index)] <= row_i.row_bits;
    end
    if (cmd_i.fetch) begin
      row_q <= adj_mem[depth_q[NIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.descend) begin
      colors_q[depth_q[NIW-1:0]] <= pick;
    end
    if (cmd_i.load_out) begin
      res_q <= count_q;
    end
  end

  assign stat_o.empty_graph = (active_nodes == '0);
  assign stat_o.found       = |allowed;
  assign stat_o.leaf        = ((depth_q + DW'(1)) == active_nodes);
  assign stat_o.root        = (depth_q == '0);
  assign count_o            = res_q;

endmodule

### sv/graph_coloring_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_coloring_counter_unit: proper coloring counter, top level
// Counts k-colorings of a loaded graph by depth-first backtracking.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  carries adjacency rows, one request per cycle while idle. Row i
//          bit j marks an edge i-j; only bits below the node's own index are
//          used. Rows at MAX_NODES or above are dropped.
//   A request with last_row set stores its row, then starts the search.
//   req_i.ready stays low until the search ends and its count is placed in
//   the result register.
//   rsp_o  gives one result per last row: the count, saturated at all ones,
//          and a flag that is set when it saturated.
//   cfg_i  writes node_count (index 0) and color_count (index 1); it is
//          always ready. Write only while no search is pending.
// Timing: each search step is a registered read of the node's row, then the
//   conflict check; there is one step per node visit and per backtrack, and
//   a hand-off to the result register at the end: latency grows with the
//   size of the search tree.
// Reset: node_count 20, color_count 3, result channel empty. Row storage is
//   not cleared; every row a search uses must be written first.
// Stall: a result waiting on rsp_o does not block new rows; the next search
//   holds its count until the earlier result is taken.
// ----------------------------------------------------------------------------
module graph_coloring_counter_unit import gcc_pkg::*; #(
  parameter int MAX_NODES  = 32,
  parameter int MAX_COLORS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcc_stream_if.sink   req_i,
  gcc_stream_if.source rsp_o,
  gcc_stream_if.sink   cfg_i
);

  // configuration registers
  logic [NODE_COUNT_W-1:0]  node_count_q;
  logic [COLOR_COUNT_W-1:0] color_count_q;

  gcc_cmd_t           cmd;
  gcc_stat_t          stat;
  logic [COUNT_W-1:0] count;
  gcc_row_t           row;
  gcc_cfg_t           cfg;

  assign row = req_i.payload;
  assign cfg = cfg_i.payload;

  // config port never stalls; unknown indexes are ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NODE_COUNT_RST;
      color_count_q <= COLOR_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg.index)
        CFG_NODE_COUNT:  node_count_q  <= cfg.data[NODE_COUNT_W-1:0];
        CFG_COLOR_COUNT: color_count_q <= cfg.data[COLOR_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: owns both handshakes and the result valid
  gcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_last_i  (row.last_row),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // row memory, color cells, conflict check, counter
  gcc_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_COLORS (MAX_COLORS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_i         (row),
    .node_count_i  (node_count_q),
    .color_count_i (color_count_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .count_o       (count)
  );

  // a true count never reaches all ones, so all ones means saturation
  gcc_result_t result;
  assign result.coloring_count  = count;
  assign result.count_saturated = &count;
  assign rsp_o.payload          = result;

endmodule

### test/gcc_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcc_scoreboard_pkg: coloring count predictor and result scoreboard
// Mirrors the row store and the two count registers, recounts the colorings
// on every last-row request and checks results in order.
// ----------------------------------------------------------------------------
package gcc_scoreboard_pkg;
  import gcc_pkg::*;

  localparam int unsigned NODE_LIMIT  = 32;
  localparam int unsigned COLOR_LIMIT = 4;

  typedef logic [ROW_W-1:0] row_mem_t [NODE_LIMIT];

  function automatic int unsigned clamp(input int unsigned v, input int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // Iterative depth-first count; returns the number of search steps taken,
  // stopping early once step_cap is reached (total is then meaningless).
  function automatic int unsigned count_colorings(
    input  row_mem_t           rows,
    input  int unsigned        nodes,
    input  int unsigned        colors,
    input  int unsigned        step_cap,
    output logic [COUNT_W-1:0] total
  );
    logic [2:0]  hue [NODE_LIMIT];
    int unsigned next_hue [NODE_LIMIT];
    int unsigned d, c, j, steps;
    bit          ok, found, done;
    total = '0;
    steps = 0;
    if (nodes == 0) begin
      total = 1;
      return 0;
    end
    d = 0;
    next_hue[0] = 0;
    done = 1'b0;
    while (!done && steps < step_cap) begin
      steps++;
      found = 1'b0;
      c = next_hue[d];
      while (c < colors && !found) begin
        ok = 1'b1;
        for (j = 0; j < d; j++)
          if (rows[d][j] && hue[j] == 3'(c)) ok = 1'b0;
        if (ok) found = 1'b1;
        else c++;
      end
      if (found) begin
        next_hue[d] = c + 1;
        if (d == nodes - 1) begin
          if (total != '1) total++;  // clamp at all ones
        end else begin
          hue[d] = 3'(c);
          d++;
          next_hue[d] = 0;
        end
      end else if (d == 0) begin
        done = 1'b1;
      end else begin
        d--;
      end
    end
    return steps;
  endfunction

  class coloring_scoreboard;
    row_mem_t                 rows;
    logic [NODE_COUNT_W-1:0]  node_reg;
    logic [COLOR_COUNT_W-1:0] color_reg;
    gcc_result_t              expected_q [$];
    int unsigned              errors;
    int unsigned              searches;
    int unsigned              widest;
    logic [COUNT_W-1:0]       top_count;

    function new();
      foreach (rows[i]) rows[i] = '0;
      node_reg  = NODE_COUNT_RST;
      color_reg = COLOR_COUNT_RST;
      errors    = 0;
      searches  = 0;
      widest    = 0;
      top_count = '0;
    endfunction

    function void write_reg(gcc_cfg_t w);
      case (w.index)
        CFG_NODE_COUNT:  node_reg  = w.data[NODE_COUNT_W-1:0];
        CFG_COLOR_COUNT: color_reg = w.data[COLOR_COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_row(gcc_row_t r);
      gcc_result_t        want;
      logic [COUNT_W-1:0] total;
      int unsigned        nodes;
      rows[r.row_index] = r.row_bits;
      if (r.last_row) begin
        nodes = clamp(node_reg, NODE_LIMIT);
        void'(count_colorings(rows, nodes, clamp(color_reg, COLOR_LIMIT), '1, total));
        want.coloring_count  = total;
        want.count_saturated = (total == '1);
        expected_q.push_back(want);
        searches++;
        if (nodes > widest) widest = nodes;
        if (total > top_count) top_count = total;
      end
    endfunction

    function void check_result(gcc_result_t got);
      gcc_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual count %0d saturated %0b",
                 $time, got.coloring_count, got.count_saturated);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.coloring_count !== want.coloring_count) begin
        $display("%0t: coloring_count mismatch: expected %0d actual %0d",
                 $time, want.coloring_count, got.coloring_count);
        errors++;
      end
      if (got.count_saturated !== want.count_saturated) begin
        $display("%0t: count_saturated mismatch: expected %0b actual %0b",
                 $time, want.count_saturated, got.count_saturated);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for graph_coloring_counter_unit
// Loads adjacency rows, runs the backtracking search under many node and
// color settings and checks each count against an in-bench recount, with
// random gaps and stalls on the request and result channels.
// ----------------------------------------------------------------------------
module testbench;
  import gcc_pkg::*;
  import gcc_scoreboard_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned ROW_TARGET    = 1550;
  // search steps allowed per generated graph; keeps the DUT's tree small
  localparam int unsigned STEP_BUDGET   = 1500;
  // settle time that covers any row still in flight
  localparam int unsigned SETTLE_CYCLES = 8;
  // longest legal quiet stretch is one budgeted search plus a result stall
  localparam int unsigned QUIET_LIMIT   = 50000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  logic clk = 1'b0;
  logic rst_n;

  gcc_stream_if #(.payload_t(gcc_row_t))    req_if ();
  gcc_stream_if #(.payload_t(gcc_result_t)) rsp_if ();
  gcc_stream_if #(.payload_t(gcc_cfg_t))    cfg_if ();

  graph_coloring_counter_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  coloring_scoreboard sb = new();

  // stimulus-side view of the row store and registers, used to plan graphs
  row_mem_t                 planned_rows;
  logic [NODE_LIMIT-1:0]    written_rows;
  logic [NODE_COUNT_W-1:0]  node_reg;
  logic [COLOR_COUNT_W-1:0] color_reg;

  int unsigned rows_sent    = 0;
  int unsigned cfg_writes   = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;  // no gaps or stalls while set

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: every accepted request on the three channels is seen here, at
  // the rising edge, before the DUT's registers update.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) sb.note_row(req_if.payload);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.payload);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      if ((req_if.valid && req_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (rsp_if.valid && rsp_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hung search or a lost result shows up as a long quiet spell.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: timeout, no request moved for %0d cycles", $time, QUIET_LIMIT);
    $display("graph_coloring_counter_unit regression: fail");
    $finish;
  end

  // Alternates stretches with random idling and stretches without.
  initial begin : calm_drive
    forever begin
      calm = ($urandom_range(3) == 0);
      repeat ($urandom_range(100, 400)) @(posedge clk);
    end
  end

  // Result side backpressure, changed on the falling edge.
  initial begin : rsp_ready_drive
    int unsigned stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm && $urandom_range(99) < 30) stall = pick_gap();
      end
    end
  end

  // One row request. valid is left high after acceptance so back-to-back
  // requests need no extra edge; a gap lowers it first.
  task automatic send_row(input gcc_row_t r);
    int unsigned gap;
    gap = calm ? 0 : (($urandom_range(99) < 55) ? 0 : pick_gap());
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    planned_rows[r.row_index] = r.row_bits;
    written_rows[r.row_index] = 1'b1;
    rows_sent++;
  endtask

  task automatic drive_row(input int unsigned idx, input logic [ROW_W-1:0] bits,
                           input logic last);
    gcc_row_t r;
    r.row_index = ROW_IDX_W'(idx);
    r.row_bits  = bits;
    r.last_row  = last;
    send_row(r);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= gcc_cfg_t'{index: idx, data: data};
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_NODE_COUNT:  node_reg  = data[NODE_COUNT_W-1:0];
      CFG_COLOR_COUNT: color_reg = data[COLOR_COUNT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Idle the row channel, wait out every pending count, then let any row
  // still in the pipe settle before registers are touched.
  task automatic quiesce();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input logic [CFG_DATA_W-1:0] nodes,
                            input logic [CFG_DATA_W-1:0] colors);
    quiesce();
    cfg_write(CFG_NODE_COUNT, nodes);
    cfg_write(CFG_COLOR_COUNT, colors);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    gcc_row_t           batch [$];
    gcc_row_t           r, tmp;
    row_mem_t           trial;
    logic [COUNT_W-1:0] unused_count;
    int unsigned        n_act, k_act, pct, attempt, steps, nval, cval, batches, extra;
    int                 i, j, b;

    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    node_reg     = NODE_COUNT_RST;
    color_reg    = COLOR_COUNT_RST;
    written_rows = '0;
    foreach (planned_rows[k]) planned_rows[k] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: edge cases of the counts and the row fields ---
    // two nodes joined by one edge; row 0 all ones has no bits below itself
    set_counts(8'd2, 8'd2);
    drive_row(0, '1, 1'b0);
    drive_row(1, 32'h0000_0001, 1'b1);
    // edge removed; bits at or above the node's own index are ignored
    drive_row(1, 32'hFFFF_FFFE, 1'b1);
    // zero colors (upper data bits dropped): nothing can be colored
    quiesce();
    cfg_write(CFG_COLOR_COUNT, 8'hF8);
    drive_row(31, '1, 1'b1);
    // zero nodes: the empty graph still has one coloring
    quiesce();
    cfg_write(CFG_NODE_COUNT, 8'hC0);
    drive_row(31, '0, 1'b1);
    // single node, single color; last mark on a row the search never reads
    set_counts(8'd1, 8'd1);
    drive_row(17, 32'h0F0F_0F0F, 1'b1);
    // triangle under 3, 2, 4 and an over-range color count
    set_counts(8'd3, 8'd3);
    drive_row(0, '0, 1'b0);
    drive_row(1, 32'h0000_0001, 1'b0);
    drive_row(2, 32'h0000_0003, 1'b1);
    quiesce();
    cfg_write(CFG_IDX_TOP, 8'hFF);  // unmapped index, must be ignored
    cfg_write(CFG_COLOR_COUNT, 8'd2);
    drive_row(2, 32'h0000_0003, 1'b1);
    quiesce();
    cfg_write(CFG_COLOR_COUNT, 8'd4);
    drive_row(2, 32'h0000_0003, 1'b1);
    quiesce();
    cfg_write(CFG_COLOR_COUNT, 8'd7);
    drive_row(1, '0, 1'b1);

    // --- random phases: new register setting, then a few graphs each ---
    while (rows_sent < ROW_TARGET) begin
      quiesce();
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0:       nval = 0;
          1:       nval = 1;
          2:       nval = NODE_LIMIT;
          default: nval = 63;  // clamps to the node limit
        endcase
      end else begin
        nval = $urandom_range(2, 12);
      end
      cval = ($urandom_range(99) < 30) ? $urandom_range(7) : $urandom_range(2, 4);
      if ($urandom_range(4) != 0)
        cfg_write(CFG_NODE_COUNT, {2'($urandom_range(3)), 6'(nval)});
      if ($urandom_range(4) != 0)
        cfg_write(CFG_COLOR_COUNT, {5'($urandom()), 3'(cval)});
      if ($urandom_range(4) == 0)
        cfg_write(CFG_IDX_TOP - CFG_IDX_W'($urandom_range(13)), CFG_DATA_W'($urandom()));
      n_act = clamp(node_reg, NODE_LIMIT);
      k_act = clamp(color_reg, COLOR_LIMIT);

      batches = $urandom_range(1, 3);
      for (b = 0; b < batches; b++) begin
        // Pick rows to (re)write and their edges; densify until the search
        // tree fits the budget, ending with a complete graph if need be.
        pct = $urandom_range(15, 75);
        for (attempt = 0; attempt < 8; attempt++) begin
          trial = planned_rows;
          batch.delete();
          for (i = 0; i < int'(n_act); i++) begin
            if (attempt == 7 || !written_rows[i] || $urandom_range(3) != 0) begin
              r.row_index = ROW_IDX_W'(i);
              r.row_bits  = $urandom();
              r.last_row  = 1'b0;
              for (j = 0; j < i; j++)
                r.row_bits[j] = (attempt == 7) || ($urandom_range(99) < pct);
              batch.push_back(r);
              trial[i] = r.row_bits;
            end
          end
          steps = count_colorings(trial, n_act, k_act, STEP_BUDGET, unused_count);
          if (steps < STEP_BUDGET) break;
          pct = (pct > 85) ? 100 : pct + 15;
        end
        // unused rows ride along as noise
        if (n_act < NODE_LIMIT) begin
          extra = $urandom_range(2);
          for (i = 0; i < int'(extra); i++) begin
            r.row_index = ROW_IDX_W'($urandom_range(NODE_LIMIT - 1, n_act));
            r.row_bits  = $urandom();
            r.last_row  = 1'b0;
            batch.push_back(r);
          end
        end
        if (batch.size() == 0) begin
          r.row_index = ROW_IDX_W'($urandom_range(NODE_LIMIT - 1));
          r.row_bits  = (r.row_index < n_act) ? trial[r.row_index] : $urandom();
          r.last_row  = 1'b0;
          batch.push_back(r);
        end
        for (i = batch.size() - 1; i > 0; i--) begin
          j        = $urandom_range(i);
          tmp      = batch[i];
          batch[i] = batch[j];
          batch[j] = tmp;
        end
        r          = batch[batch.size() - 1];
        r.last_row = 1'b1;
        batch[batch.size() - 1] = r;
        for (i = 0; i < batch.size(); i++) send_row(batch[i]);
      end

      // sometimes leave stray rows that start nothing before the next setting
      if ($urandom_range(4) == 0) begin
        extra = $urandom_range(1, 3);
        for (i = 0; i < int'(extra); i++) begin
          r.row_index = ROW_IDX_W'($urandom());
          r.row_bits  = $urandom();
          r.last_row  = 1'b0;
          send_row(r);
        end
      end
    end

    quiesce();
    $display("covered %0d searches from %0d row requests and %0d register writes",
             sb.searches, rows_sent, cfg_writes);
    $display("graphs up to %0d nodes, largest count seen %0d", sb.widest, sb.top_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("graph_coloring_counter_unit regression: pass");
    end else begin
      $display("graph_coloring_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gcc_pkg.sv
sv/gcc_stream_if.sv
sv/gcc_ctrl.sv
sv/gcc_dp.sv
sv/graph_coloring_counter_unit.sv
test/gcc_scoreboard_pkg.sv
test/testbench.sv
